[rtl/pcse_pkg.sv]
// ----------------------------------------------------------------------------
// pcse_pkg
// Shared types, constants and helpers for the periodic cubic spline evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcse_pkg;

  localparam int Q_W           = 32;
  localparam int PROD_W        = 2 * Q_W;
  localparam int ACC_W         = 36;
  localparam int KNOT_COUNT_W  = 7;
  localparam int ROW_W         = 6;
  localparam int ORDER_W       = 2;
  localparam int STEP_W        = 3;
  localparam int MAX_KNOTS_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [KNOT_COUNT_W-1:0] KNOT_COUNT_RST = 7'd2;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_EVAL = 1'b1;

  localparam logic [ORDER_W-1:0] ORDER_VALUE = 2'd0;
  localparam logic [ORDER_W-1:0] ORDER_SLOPE = 2'd1;
  localparam logic [ORDER_W-1:0] ORDER_CURVE = 2'd2;
  localparam logic [ORDER_W-1:0] ORDER_NONE  = 2'd3;

  typedef struct packed {
    logic signed [Q_W-1:0] knot;
    logic signed [Q_W-1:0] coef_const;
    logic signed [Q_W-1:0] coef_lin;
    logic signed [Q_W-1:0] coef_quad;
    logic signed [Q_W-1:0] coef_cube;
  } row_t;

  typedef struct packed {
    logic                start;
    logic signed [Q_W:0] dividend;
    logic [Q_W-1:0]      divisor;
  } rem_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] rem;
  } rem_rsp_t;

  typedef struct packed {
    logic signed [Q_W-1:0] value;
    logic                  clip;
  } sat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_REM,
    ST_SEARCH_ADDR,
    ST_SEARCH_CMP,
    ST_INDEX,
    ST_FETCH,
    ST_MUL,
    ST_RND,
    ST_WB,
    ST_ACC,
    ST_DONE
  } ctl_state_t;

  typedef enum logic [2:0] {
    REM_IDLE,
    REM_ABS,
    REM_RUN,
    REM_FIX,
    REM_DONE
  } rem_state_t;

  typedef enum logic [2:0] {
    OPND_DT,
    OPND_DT2,
    OPND_DT3,
    OPND_LIN,
    OPND_QUAD,
    OPND_CUBE
  } opnd_t;

  typedef enum logic [1:0] {
    DST_DT2,
    DST_DT3,
    DST_ACC
  } dst_t;

  typedef enum logic [1:0] {
    SCALE_1,
    SCALE_2,
    SCALE_3,
    SCALE_6
  } scale_t;

  typedef struct packed {
    opnd_t  a_sel;
    opnd_t  b_sel;
    dst_t   dst;
    scale_t scale;
    logic   last;
  } poly_op_t;

  // clip a wide signed sum to q16.16 range
  function automatic sat_t sat_q(input logic signed [ACC_W-1:0] v);
    sat_t s;
    if (v[ACC_W-1:Q_W-1] == {(ACC_W-Q_W+1){v[ACC_W-1]}}) begin
      s.value = v[Q_W-1:0];
      s.clip  = 1'b0;
    end else begin
      s.value = v[ACC_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
      s.clip  = 1'b1;
    end
    return s;
  endfunction

  // multiply schedule per derivative order
  function automatic poly_op_t poly_op(input logic [ORDER_W-1:0] order,
                                       input logic [STEP_W-1:0]  step);
    poly_op_t op;
    op = '{OPND_DT, OPND_DT, DST_ACC, SCALE_1, 1'b1};
    case (order)
      ORDER_VALUE: begin
        case (step)
          3'd0:    op = '{OPND_DT,   OPND_DT,  DST_DT2, SCALE_1, 1'b0};
          3'd1:    op = '{OPND_DT2,  OPND_DT,  DST_DT3, SCALE_1, 1'b0};
          3'd2:    op = '{OPND_LIN,  OPND_DT,  DST_ACC, SCALE_1, 1'b0};
          3'd3:    op = '{OPND_QUAD, OPND_DT2, DST_ACC, SCALE_1, 1'b0};
          default: op = '{OPND_CUBE, OPND_DT3, DST_ACC, SCALE_1, 1'b1};
        endcase
      end
      ORDER_SLOPE: begin
        case (step)
          3'd0:    op = '{OPND_DT,   OPND_DT,  DST_DT2, SCALE_1, 1'b0};
          3'd1:    op = '{OPND_QUAD, OPND_DT,  DST_ACC, SCALE_2, 1'b0};
          default: op = '{OPND_CUBE, OPND_DT2, DST_ACC, SCALE_3, 1'b1};
        endcase
      end
      ORDER_CURVE: op = '{OPND_CUBE, OPND_DT, DST_ACC, SCALE_6, 1'b1};
      default:     op = '{OPND_DT, OPND_DT, DST_ACC, SCALE_1, 1'b1};
    endcase
    return op;
  endfunction

endpackage

[rtl/pcse_tables.sv]
// ----------------------------------------------------------------------------
// pcse_tables
// Knot and coefficient rows, one write port and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcse_tables #(
  parameter int  MAX_KNOTS = pcse_pkg::MAX_KNOTS_DEF,
  localparam int AW        = $clog2(MAX_KNOTS)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  pcse_pkg::row_t  wr_row,
  input  logic [AW-1:0]   rd_addr,
  output pcse_pkg::row_t  rd_row
);
  import pcse_pkg::*;

  row_t mem [MAX_KNOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    rd_row <= mem[rd_addr];
  end

endmodule

[rtl/pcse_rem_unit.sv]
// ----------------------------------------------------------------------------
// pcse_rem_unit
// Bit-serial floor remainder of a signed offset by a positive span.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcse_rem_unit (
  input  logic               clk,
  input  logic               rst,
  input  pcse_pkg::rem_req_t req,
  output pcse_pkg::rem_rsp_t rsp
);
  import pcse_pkg::*;

  localparam int CNT_W = $clog2(Q_W);

  rem_state_t          state;
  rem_state_t          state_next;
  logic signed [Q_W:0] dividend;
  logic signed [Q_W:0] dividend_neg;
  logic [Q_W-1:0]      divisor;
  logic [Q_W-1:0]      mag;
  logic [Q_W-1:0]      rem;
  logic                neg;
  logic [CNT_W-1:0]    cnt;
  logic [Q_W:0]        trial;
  logic [Q_W:0]        trial_sub;

  assign dividend_neg = -dividend;
  assign trial        = {rem, mag[Q_W-1]};
  assign trial_sub    = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= REM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rsp.done   = 1'b0;
    rsp.rem    = rem;
    case (state)
      REM_IDLE: begin
        if (req.start) begin
          state_next = REM_ABS;
        end
      end
      REM_ABS: state_next = REM_RUN;
      REM_RUN: begin
        if (cnt == CNT_W'(Q_W - 1)) begin
          state_next = REM_FIX;
        end
      end
      REM_FIX: state_next = REM_DONE;
      REM_DONE: begin
        rsp.done   = 1'b1;
        state_next = REM_IDLE;
      end
      default: state_next = REM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      REM_IDLE: begin
        if (req.start) begin
          dividend <= req.dividend;
          divisor  <= req.divisor;
        end
      end
      REM_ABS: begin
        neg <= dividend[Q_W];
        mag <= dividend[Q_W] ? dividend_neg[Q_W-1:0] : dividend[Q_W-1:0];
        rem <= '0;
        cnt <= '0;
      end
      REM_RUN: begin
        rem <= trial_sub[Q_W] ? trial[Q_W-1:0] : trial_sub[Q_W-1:0];
        mag <= mag << 1;
        cnt <= cnt + CNT_W'(1);
      end
      REM_FIX: begin
        // negative offset wraps up from the span
        if (neg && rem != '0) begin
          rem <= divisor - rem;
        end
      end
      default: ;
    endcase
  end

endmodule

[rtl/pcse_mul_unit.sv]
// ----------------------------------------------------------------------------
// pcse_mul_unit
// Shared q16.16 multiplier: registered product, then round half up and clip.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcse_mul_unit #(
  parameter int FRAC_BITS = pcse_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic signed [pcse_pkg::Q_W-1:0] op_a,
  input  logic signed [pcse_pkg::Q_W-1:0] op_b,
  output pcse_pkg::sat_t                  q
);
  import pcse_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic signed [PROD_W-1:0] a_ext;
  logic signed [PROD_W-1:0] b_ext;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;
  sat_t                     q_next;

  assign a_ext   = {{Q_W{op_a[Q_W-1]}}, op_a};
  assign b_ext   = {{Q_W{op_b[Q_W-1]}}, op_b};
  assign rounded = prod + HALF;
  assign shifted = rounded >>> FRAC_BITS;

  always_comb begin
    if (shifted[PROD_W-1:Q_W-1] == {(PROD_W-Q_W+1){shifted[PROD_W-1]}}) begin
      q_next.value = shifted[Q_W-1:0];
      q_next.clip  = 1'b0;
    end else begin
      q_next.value = shifted[PROD_W-1] ? {1'b1, {(Q_W-1){1'b0}}}
                                       : {1'b0, {(Q_W-1){1'b1}}};
      q_next.clip  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= a_ext * b_ext;
    q    <= q_next;
  end

endmodule

[rtl/periodic_cubic_spline_eval.sv]
// ----------------------------------------------------------------------------
// periodic_cubic_spline_eval
// Periodic piecewise cubic spline evaluator, signed q16.16.
// ----------------------------------------------------------------------------
// A load beat (action 0) writes one knot and its four segment coefficients
// and gives no result. An evaluate beat (action 1) wraps query_param into
// the span from first to last knot by a bit-serial remainder by the span,
// finds the segment by binary search over the knot table (at most 7 steps
// for 64 knots) and returns the value, slope or curvature with a saturation
// flag, worked out on the one shared multiplier. Evaluations that return
// zero (fewer than two knots, order 3, empty or negative span) skip the
// search and the multiplier. One item is in work at a time; a finished
// result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_cubic_spline_eval #(
  parameter int MAX_KNOTS = pcse_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = pcse_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [pcse_pkg::KNOT_COUNT_W-1:0]        cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic                                     action,
  input  logic [pcse_pkg::ROW_W-1:0]               row_index,
  input  logic signed [pcse_pkg::Q_W-1:0]          knot_pos,
  input  logic signed [pcse_pkg::Q_W-1:0]          coef_const,
  input  logic signed [pcse_pkg::Q_W-1:0]          coef_lin,
  input  logic signed [pcse_pkg::Q_W-1:0]          coef_quad,
  input  logic signed [pcse_pkg::Q_W-1:0]          coef_cube,
  input  logic signed [pcse_pkg::Q_W-1:0]          query_param,
  input  logic [pcse_pkg::ORDER_W-1:0]             deriv_order,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [pcse_pkg::Q_W-1:0]          spline_value,
  output logic                                     saturated
);
  import pcse_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 1);

  ctl_state_t               state;
  ctl_state_t               state_next;
  logic [KNOT_COUNT_W-1:0]  knot_count;
  int                       kc;
  logic [CW-1:0]            n_calc;
  logic [CW-1:0]            n_reg;
  logic signed [Q_W-1:0]    t_reg;
  logic [ORDER_W-1:0]       order_reg;
  logic signed [Q_W-1:0]    first;
  logic signed [Q_W-1:0]    tm;
  logic [CW-1:0]            lo;
  logic [CW-1:0]            cnt;
  logic [CW-1:0]            mid;
  logic [CW-1:0]            idx;
  logic signed [Q_W-1:0]    dt;
  logic signed [Q_W-1:0]    dt2;
  logic signed [Q_W-1:0]    dt3;
  logic signed [Q_W-1:0]    lin;
  logic signed [Q_W-1:0]    quad;
  logic signed [Q_W-1:0]    cube;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_init;
  logic signed [ACC_W-1:0]  addend;
  logic signed [ACC_W-1:0]  q_ext;
  logic signed [ACC_W-1:0]  scaled;
  logic                     clip;
  logic [STEP_W-1:0]        step;
  logic                     out_load;
  logic                     wr_en;
  logic [AW-1:0]            wr_addr;
  row_t                     wr_row;
  logic [AW-1:0]            rd_addr;
  row_t                     rd_row;
  rem_req_t                 rem_req;
  rem_rsp_t                 rem_rsp;
  logic signed [Q_W:0]      span;
  logic signed [Q_W:0]      x_diff;
  logic signed [Q_W:0]      dt_diff;
  sat_t                     dt_sat;
  sat_t                     acc_sat;
  sat_t                     q;
  poly_op_t                 op;
  logic signed [Q_W-1:0]    mul_a;
  logic signed [Q_W-1:0]    mul_b;

  assign cfg_ready = 1'b1;

  // table write on a load beat
  assign wr_en   = in_valid && in_ready && action == ACT_LOAD
                   && int'(row_index) < MAX_KNOTS;
  assign wr_addr = AW'(row_index);
  assign wr_row  = '{knot_pos, coef_const, coef_lin, coef_quad, coef_cube};

  pcse_tables #(
    .MAX_KNOTS(MAX_KNOTS)
  ) u_tables (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_row (wr_row),
    .rd_addr(rd_addr),
    .rd_row (rd_row)
  );

  pcse_rem_unit u_rem (
    .clk(clk),
    .rst(rst),
    .req(rem_req),
    .rsp(rem_rsp)
  );

  pcse_mul_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) u_mul (
    .clk (clk),
    .op_a(mul_a),
    .op_b(mul_b),
    .q   (q)
  );

  always_comb begin
    kc     = int'(knot_count);
    n_calc = (kc > MAX_KNOTS) ? CW'(MAX_KNOTS) : CW'(kc);
  end

  assign span    = {rd_row.knot[Q_W-1], rd_row.knot} - {first[Q_W-1], first};
  assign x_diff  = {t_reg[Q_W-1], t_reg} - {first[Q_W-1], first};
  assign dt_diff = {tm[Q_W-1], tm} - {rd_row.knot[Q_W-1], rd_row.knot};
  assign dt_sat  = sat_q(ACC_W'(dt_diff));
  assign acc_sat = sat_q(acc);
  assign mid     = lo + (cnt >> 1);

  always_comb begin
    idx = (lo == '0) ? '0 : lo - CW'(1);
    if (idx > n_reg - CW'(2)) begin
      idx = n_reg - CW'(2);
    end
  end

  always_comb begin
    case (order_reg)
      ORDER_VALUE: acc_init = ACC_W'($signed(rd_row.coef_const));
      ORDER_SLOPE: acc_init = ACC_W'($signed(rd_row.coef_lin));
      ORDER_CURVE: acc_init = ACC_W'($signed(rd_row.coef_quad)) <<< 1;
      default:     acc_init = '0;
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    op = poly_op(order_reg, step);
    case (op.a_sel)
      OPND_DT:   mul_a = dt;
      OPND_DT2:  mul_a = dt2;
      OPND_DT3:  mul_a = dt3;
      OPND_LIN:  mul_a = lin;
      OPND_QUAD: mul_a = quad;
      OPND_CUBE: mul_a = cube;
      default:   mul_a = '0;
    endcase
    case (op.b_sel)
      OPND_DT:   mul_b = dt;
      OPND_DT2:  mul_b = dt2;
      OPND_DT3:  mul_b = dt3;
      OPND_LIN:  mul_b = lin;
      OPND_QUAD: mul_b = quad;
      OPND_CUBE: mul_b = cube;
      default:   mul_b = '0;
    endcase
  end

  always_comb begin
    q_ext = ACC_W'($signed(q.value));
    case (op.scale)
      SCALE_1: scaled = q_ext;
      SCALE_2: scaled = q_ext <<< 1;
      SCALE_3: scaled = q_ext + (q_ext <<< 1);
      SCALE_6: scaled = (q_ext <<< 2) + (q_ext <<< 1);
      default: scaled = q_ext;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    in_ready         = 1'b0;
    rd_addr          = '0;
    out_load         = 1'b0;
    rem_req.start    = 1'b0;
    rem_req.dividend = x_diff;
    rem_req.divisor  = span[Q_W-1:0];
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && action == ACT_EVAL) begin
          if (n_calc < CW'(2) || deriv_order == ORDER_NONE) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_FIRST;
          end
        end
      end
      ST_FIRST: begin
        rd_addr    = AW'(n_reg - CW'(1));
        state_next = ST_LAST;
      end
      ST_LAST: begin
        if (!span[Q_W] && span != '0) begin
          rem_req.start = 1'b1;
          state_next    = ST_REM;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_REM: begin
        if (rem_rsp.done) begin
          state_next = ST_SEARCH_ADDR;
        end
      end
      ST_SEARCH_ADDR: begin
        if (cnt == '0) begin
          state_next = ST_INDEX;
        end else begin
          rd_addr    = AW'(mid);
          state_next = ST_SEARCH_CMP;
        end
      end
      ST_SEARCH_CMP: state_next = ST_SEARCH_ADDR;
      ST_INDEX: begin
        rd_addr    = AW'(idx);
        state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_MUL;
      ST_MUL:   state_next = ST_RND;
      ST_RND:   state_next = ST_WB;
      ST_WB: begin
        if (op.dst == DST_ACC) begin
          state_next = ST_ACC;
        end else if (op.last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_MUL;
        end
      end
      ST_ACC: begin
        state_next = op.last ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid && action == ACT_EVAL) begin
          n_reg     <= n_calc;
          t_reg     <= query_param;
          order_reg <= deriv_order;
          acc       <= '0;
          clip      <= 1'b0;
        end
      end
      ST_FIRST: first <= rd_row.knot;
      ST_REM: begin
        if (rem_rsp.done) begin
          tm  <= first + rem_rsp.rem;
          lo  <= '0;
          cnt <= n_reg;
        end
      end
      ST_SEARCH_CMP: begin
        // upper bound: move past knots at or below the wrapped parameter
        if (!(tm < $signed(rd_row.knot))) begin
          lo  <= mid + CW'(1);
          cnt <= cnt - (cnt >> 1) - CW'(1);
        end else begin
          cnt <= cnt >> 1;
        end
      end
      ST_FETCH: begin
        dt   <= dt_sat.value;
        clip <= clip | dt_sat.clip;
        lin  <= rd_row.coef_lin;
        quad <= rd_row.coef_quad;
        cube <= rd_row.coef_cube;
        acc  <= acc_init;
        step <= '0;
      end
      ST_WB: begin
        clip <= clip | q.clip;
        case (op.dst)
          DST_DT2: begin
            dt2  <= q.value;
            step <= step + STEP_W'(1);
          end
          DST_DT3: begin
            dt3  <= q.value;
            step <= step + STEP_W'(1);
          end
          DST_ACC: addend <= scaled;
          default: ;
        endcase
      end
      ST_ACC: begin
        acc  <= acc + addend;
        step <= step + STEP_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knot_count <= KNOT_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      knot_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      spline_value <= acc_sat.value;
      saturated    <= clip | acc_sat.clip;
    end
  end

endmodule

[rtl/pcse_checker.sv]
// ----------------------------------------------------------------------------
// pcse_checker
// Port-level checks for the spline evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcse_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           action,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic signed [pcse_pkg::Q_W-1:0] spline_value,
  input logic                           saturated
);
  import pcse_pkg::*;

  // result beat holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(spline_value) && $stable(saturated))
    else $error("result beat changed while stalled");

  // a load beat never raises a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_LOAD && !out_valid |=> !out_valid)
    else $error("load beat produced a result");

  // an evaluate beat closes the input until it completes
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action == ACT_EVAL |=> !in_ready)
    else $error("input open while evaluating");

  // a new result only appears at the end of an evaluation
  a_out_from_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without evaluation");

  // reset leaves the block empty and open
  a_reset_state: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("bad state after reset");

endmodule

bind periodic_cubic_spline_eval pcse_checker u_pcse_checker (.*);

[tb/periodic_cubic_spline_eval_test.sv]
// ----------------------------------------------------------------------------
// periodic_cubic_spline_eval_test
// Self-checking bench for the periodic cubic spline evaluator.
// ----------------------------------------------------------------------------
// A short table of hand-picked beats covers reset, wrap-around, saturation,
// empty spans, too few knots and unsorted knots. Random phases follow: each
// rebuilds the knot table if it has two knots or more, sets a new knot
// count while the block is idle and mixes evaluations near the span with
// stray loads. Results are checked against fixed values or a bit-accurate
// q16.16 model kept in the bench. The sender works in bursts, the receiver
// stalls on its own pattern and once long enough to back the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_cubic_spline_eval_test;
  import pcse_pkg::*;

  localparam int FRAC         = FRAC_BITS_DEF;
  localparam int TABLE_ROWS   = MAX_KNOTS_DEF;
  localparam int RANDOM_BEATS = 950;
  localparam int DRAIN_PAUSE  = 100;
  localparam int HOLD_CYCLES  = 300;
  localparam int WATCHDOG     = 5000;

  localparam logic signed [31:0] Q_ONE    = 32'sh0001_0000;
  localparam logic signed [31:0] Q_TOP    = 32'sh7fff_ffff;
  localparam logic signed [31:0] Q_BOTTOM = 32'sh8000_0000;
  localparam longint Q_HI = 64'sd2147483647;
  localparam longint Q_LO = -64'sd2147483648;

  typedef struct {
    bit                  is_cfg;
    logic [6:0]          cfg_val;
    logic                act;
    logic [5:0]          row;
    logic signed [31:0]  knot;
    logic signed [31:0]  c0;
    logic signed [31:0]  c1;
    logic signed [31:0]  c2;
    logic signed [31:0]  c3;
    logic signed [31:0]  t;
    logic [1:0]          order;
    bit                  typed;
    logic signed [31:0]  want_val;
    bit                  want_sat;
  } stim_t;

  typedef struct {
    logic signed [31:0] value;
    logic               clip;
  } spline_result_t;

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [6:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               action;
  logic [5:0]         row_index;
  logic signed [31:0] knot_pos;
  logic signed [31:0] coef_const;
  logic signed [31:0] coef_lin;
  logic signed [31:0] coef_quad;
  logic signed [31:0] coef_cube;
  logic signed [31:0] query_param;
  logic [1:0]         deriv_order;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] spline_value;
  logic               saturated;

  logic signed [31:0] knot_mem  [0:TABLE_ROWS-1];
  logic signed [31:0] const_mem [0:TABLE_ROWS-1];
  logic signed [31:0] lin_mem   [0:TABLE_ROWS-1];
  logic signed [31:0] quad_mem  [0:TABLE_ROWS-1];
  logic signed [31:0] cube_mem  [0:TABLE_ROWS-1];
  int unsigned        knot_count_q;

  spline_result_t expected_results[$];
  stim_t          directed_rows[$];

  int mismatches;
  int beats_sent;
  int burst_left;
  bit gap_free;
  int hold_asks;
  int hold_done;
  int idle_cycles;

  periodic_cubic_spline_eval dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .action      (action),
    .row_index   (row_index),
    .knot_pos    (knot_pos),
    .coef_const  (coef_const),
    .coef_lin    (coef_lin),
    .coef_quad   (coef_quad),
    .coef_cube   (coef_cube),
    .query_param (query_param),
    .deriv_order (deriv_order),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .spline_value(spline_value),
    .saturated   (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // q16.16 arithmetic of the spline model

  function automatic logic signed [31:0] clip_q(input longint v, inout bit clip);
    if (v > Q_HI) begin
      clip = 1'b1;
      return Q_TOP;
    end
    if (v < Q_LO) begin
      clip = 1'b1;
      return Q_BOTTOM;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] x,
                                                input logic signed [31:0] y,
                                                inout bit clip);
    longint p;
    p = longint'(x) * longint'(y) + (64'sd1 <<< (FRAC - 1));
    return clip_q(p >>> FRAC, clip);
  endfunction

  function automatic void spline_eval(input logic [1:0] order,
                                      input logic signed [31:0] t,
                                      output logic signed [31:0] val,
                                      output logic clip);
    int unsigned n;
    longint first, span, r, tm, s;
    int unsigned lo, cnt, half, mid, idx;
    logic signed [31:0] dt, dt2, dt3, a, b, c, d;
    bit cl;
    val = '0;
    cl  = 1'b0;
    clip = 1'b0;
    n = knot_count_q;
    if (n > TABLE_ROWS) n = TABLE_ROWS;
    if (n < 2 || order == ORDER_NONE) return;
    first = longint'(knot_mem[0]);
    span  = longint'(knot_mem[n-1]) - first;
    if (span <= 0) return;
    r = (longint'(t) - first) % span;
    if (r < 0) r += span;
    tm = r + first;
    lo  = 0;
    cnt = n;
    while (cnt > 0) begin
      half = cnt / 2;
      mid  = lo + half;
      if (!(tm < longint'(knot_mem[mid]))) begin
        lo  = mid + 1;
        cnt = cnt - (half + 1);
      end else begin
        cnt = half;
      end
    end
    idx = (lo == 0) ? 0 : lo - 1;
    if (idx > n - 2) idx = n - 2;
    dt = clip_q(tm - longint'(knot_mem[idx]), cl);
    a = const_mem[idx];
    b = lin_mem[idx];
    c = quad_mem[idx];
    d = cube_mem[idx];
    case (order)
      ORDER_VALUE: begin
        dt2 = fx_mul(dt, dt, cl);
        dt3 = fx_mul(dt2, dt, cl);
        s = longint'(a) + longint'(fx_mul(b, dt, cl)) + longint'(fx_mul(c, dt2, cl))
            + longint'(fx_mul(d, dt3, cl));
      end
      ORDER_SLOPE: begin
        dt2 = fx_mul(dt, dt, cl);
        s = longint'(b) + 2 * longint'(fx_mul(c, dt, cl))
            + 3 * longint'(fx_mul(d, dt2, cl));
      end
      default: begin
        s = 2 * longint'(c) + 6 * longint'(fx_mul(d, dt, cl));
      end
    endcase
    val  = clip_q(s, cl);
    clip = cl;
  endfunction

  // beat builders

  function automatic stim_t eval_row(input logic signed [31:0] t, input logic [1:0] order);
    stim_t s;
    s.is_cfg   = 1'b0;
    s.cfg_val  = $urandom_range(0, 127);
    s.act      = ACT_EVAL;
    s.row      = $urandom_range(0, 63);
    s.knot     = $urandom;
    s.c0       = $urandom;
    s.c1       = $urandom;
    s.c2       = $urandom;
    s.c3       = $urandom;
    s.t        = t;
    s.order    = order;
    s.typed    = 1'b0;
    s.want_val = '0;
    s.want_sat = 1'b0;
    return s;
  endfunction

  function automatic stim_t load_row(input int r, input logic signed [31:0] k,
                                     input logic signed [31:0] a, input logic signed [31:0] b,
                                     input logic signed [31:0] c, input logic signed [31:0] d);
    stim_t s;
    s = eval_row($urandom, $urandom_range(0, 3));
    s.act  = ACT_LOAD;
    s.row  = r;
    s.knot = k;
    s.c0   = a;
    s.c1   = b;
    s.c2   = c;
    s.c3   = d;
    return s;
  endfunction

  function automatic stim_t eval_fixed(input logic signed [31:0] t, input logic [1:0] order,
                                       input logic signed [31:0] v, input bit sat);
    stim_t s;
    s = eval_row(t, order);
    s.typed    = 1'b1;
    s.want_val = v;
    s.want_sat = sat;
    return s;
  endfunction

  function automatic stim_t cfg_row(input logic [6:0] n);
    stim_t s;
    s = eval_row('0, ORDER_NONE);
    s.is_cfg  = 1'b1;
    s.cfg_val = n;
    return s;
  endfunction

  function automatic logic signed [31:0] to_q(input longint v);
    if (v > Q_HI) return Q_TOP;
    if (v < Q_LO) return Q_BOTTOM;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] rand_coef();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return '0;
      default: return $urandom_range(0, 32'h0008_0000) - 32'sh0004_0000;
    endcase
  endfunction

  // mostly inside or around the current span, sometimes on a knot or anywhere
  function automatic logic signed [31:0] pick_param(input int neff);
    longint first, span;
    int sel;
    sel = $urandom_range(0, 9);
    if (neff < 2 || sel == 0) return $urandom;
    if (sel == 1) return knot_mem[$urandom_range(0, neff - 1)];
    first = longint'(knot_mem[0]);
    span  = longint'(knot_mem[neff-1]) - first;
    if (span <= 0 || span >= (64'sd1 <<< 30)) return to_q(first + longint'($urandom));
    return to_q(first - span + longint'($urandom_range(0, 32'(3 * span))));
  endfunction

  // driving

  task automatic send_beat(input stim_t s);
    spline_result_t e;
    int gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    action      <= s.act;
    row_index   <= s.row;
    knot_pos    <= s.knot;
    coef_const  <= s.c0;
    coef_lin    <= s.c1;
    coef_quad   <= s.c2;
    coef_cube   <= s.c3;
    query_param <= s.t;
    deriv_order <= s.order;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
    if (s.act == ACT_LOAD) begin
      knot_mem[s.row]  = s.knot;
      const_mem[s.row] = s.c0;
      lin_mem[s.row]   = s.c1;
      quad_mem[s.row]  = s.c2;
      cube_mem[s.row]  = s.c3;
    end else begin
      if (s.typed) begin
        e.value = s.want_val;
        e.clip  = s.want_sat;
      end else begin
        spline_eval(s.order, s.t, e.value, e.clip);
      end
      expected_results.push_back(e);
    end
    if (!gap_free) begin
      burst_left--;
      if (burst_left <= 0) begin
        gap = $urandom_range(1, 15);
        burst_left = $urandom_range(1, 20);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_PAUSE) @(posedge clk);
  endtask

  task automatic set_knot_count(input logic [6:0] n);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    do @(posedge clk); while (!cfg_ready);
    knot_count_q = n;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int pidx);
    int fixed_counts[8];
    int ncfg, neff, mode, m, i, r;
    longint k, step;
    fixed_counts = '{64, 127, 2, 5, 0, 1, 65, 3};
    if (pidx < 8) begin
      ncfg = fixed_counts[pidx];
    end else begin
      case ($urandom_range(0, 19))
        0:       ncfg = $urandom_range(11, 64);
        1:       ncfg = $urandom_range(0, 127);
        2:       ncfg = $urandom_range(0, 1);
        default: ncfg = $urandom_range(2, 10);
      endcase
    end
    neff = (ncfg > TABLE_ROWS) ? TABLE_ROWS : ncfg;
    gap_free = 1'b0;
    // fresh knot table for rows in use, written before the count changes
    if (neff >= 2) begin
      mode = $urandom_range(0, 9);
      if (mode < 7) k = longint'($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE;
      else k = Q_LO + longint'($urandom_range(0, Q_ONE));
      for (i = 0; i < neff; i++) begin
        send_beat(load_row(i, (mode == 9) ? $urandom : to_q(k),
                           rand_coef(), rand_coef(), rand_coef(), rand_coef()));
        if (mode < 7) step = $urandom_range(Q_ONE / 16, 4 * Q_ONE);
        else step = $urandom_range(1, 32'(64'd4294967295 / neff));
        k += step;
      end
    end
    set_knot_count(ncfg);
    if (pidx == 3) begin
      hold_asks++;
      gap_free = 1'b1;
    end else begin
      gap_free = ($urandom_range(0, 5) == 0);
    end
    m = (neff < 2) ? 8 : $urandom_range(15, 50);
    for (i = 0; i < m; i++) begin
      if (pidx == 6 && i == m / 2) drain_results();
      if ($urandom_range(0, 7) == 0) begin
        r = $urandom_range(0, 1) ? $urandom_range(0, 63)
                                 : $urandom_range(0, (neff > 0) ? neff - 1 : 0);
        send_beat(load_row(r, pick_param(neff),
                           rand_coef(), rand_coef(), rand_coef(), rand_coef()));
      end else begin
        send_beat(eval_row(pick_param(neff),
                           ($urandom_range(0, 9) == 0) ? ORDER_NONE : $urandom_range(0, 2)));
      end
    end
  endtask

  // result side

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    spline_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat: value %h sat %b",
                                spline_value, saturated));
      end else begin
        e = expected_results.pop_front();
        if (spline_value !== e.value || saturated !== e.clip)
          note_mismatch($sformatf("result mismatch: expected value %h sat %b, got value %h sat %b",
                                  e.value, e.clip, spline_value, saturated));
      end
    end
  end

  initial begin
    int unsigned mode, mode_left, tick;
    out_ready = 1'b0;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_asks != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(64, 256);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= $urandom_range(0, 1);
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (tick % 7 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int directed_count;
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    action       = ACT_LOAD;
    row_index    = '0;
    knot_pos     = '0;
    coef_const   = '0;
    coef_lin     = '0;
    coef_quad    = '0;
    coef_cube    = '0;
    query_param  = '0;
    deriv_order  = ORDER_VALUE;
    knot_count_q = KNOT_COUNT_RST;
    mismatches   = 0;
    beats_sent   = 0;
    hold_asks    = 0;
    hold_done    = 0;
    idle_cycles  = 0;
    gap_free     = 1'b0;
    burst_left   = $urandom_range(1, 20);

    // order three straight after reset, then a simple two-knot table
    directed_rows.push_back(eval_fixed('0, ORDER_NONE, '0, 1'b0));
    directed_rows.push_back(load_row(0, '0, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    directed_rows.push_back(load_row(1, 4 * Q_ONE, '0, '0, '0, '0));
    directed_rows.push_back(eval_fixed('0, ORDER_VALUE, Q_ONE, 1'b0));
    directed_rows.push_back(eval_row(Q_ONE + Q_ONE / 2, ORDER_SLOPE));
    directed_rows.push_back(eval_row(3 * Q_ONE + 7, ORDER_CURVE));
    // t on the last knot wraps to the first
    directed_rows.push_back(eval_fixed(4 * Q_ONE, ORDER_VALUE, Q_ONE, 1'b0));
    directed_rows.push_back(eval_row(Q_TOP, ORDER_VALUE));
    directed_rows.push_back(eval_row(Q_BOTTOM, ORDER_SLOPE));
    // coefficient extremes saturate
    directed_rows.push_back(load_row(0, '0, Q_TOP, Q_TOP, Q_TOP, Q_TOP));
    directed_rows.push_back(eval_fixed(3 * Q_ONE, ORDER_VALUE, Q_TOP, 1'b1));
    directed_rows.push_back(load_row(0, '0, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM, Q_BOTTOM));
    directed_rows.push_back(eval_fixed(3 * Q_ONE, ORDER_VALUE, Q_BOTTOM, 1'b1));
    // empty and negative span
    directed_rows.push_back(load_row(1, '0, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    directed_rows.push_back(eval_fixed(Q_ONE, ORDER_VALUE, '0, 1'b0));
    directed_rows.push_back(load_row(1, -Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    directed_rows.push_back(eval_fixed(Q_ONE, ORDER_SLOPE, '0, 1'b0));
    // widest span
    directed_rows.push_back(load_row(0, Q_BOTTOM, Q_ONE / 2, -Q_ONE, Q_ONE / 4, 3));
    directed_rows.push_back(load_row(1, Q_TOP, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
    directed_rows.push_back(eval_fixed(Q_TOP, ORDER_VALUE, Q_ONE / 2, 1'b0));
    // too few knots
    directed_rows.push_back(cfg_row(0));
    directed_rows.push_back(eval_fixed(Q_ONE, ORDER_VALUE, '0, 1'b0));
    directed_rows.push_back(cfg_row(1));
    directed_rows.push_back(eval_fixed(Q_ONE, ORDER_CURVE, '0, 1'b0));
    // unsorted knots
    directed_rows.push_back(load_row(0, '0, Q_ONE, -Q_ONE, Q_ONE / 2, 5));
    directed_rows.push_back(load_row(1, 8 * Q_ONE, Q_ONE, Q_ONE, -Q_ONE, Q_ONE));
    directed_rows.push_back(load_row(2, 2 * Q_ONE, -Q_ONE, Q_ONE, Q_ONE, -Q_ONE));
    directed_rows.push_back(cfg_row(3));
    directed_rows.push_back(eval_row(Q_ONE, ORDER_VALUE));
    directed_rows.push_back(eval_row(Q_ONE + Q_ONE / 2, ORDER_SLOPE));
    directed_rows.push_back(cfg_row(2));

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) set_knot_count(directed_rows[i].cfg_val);
      else send_beat(directed_rows[i]);
    end
    directed_count = beats_sent;

    phase = 0;
    while (beats_sent - directed_count < RANDOM_BEATS) begin
      run_phase(phase);
      phase++;
    end

    drain_results();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
